[hdl/vfve_pkg.sv]
// Package: shared types, constants and the helper function of the voxel face vertex emitter.
package vfve_pkg;

	localparam int COORD_BITS = 16;
	localparam int POS_W      = 16;
	localparam int SIZE_W     = 8;
	localparam int VERT_W     = 17;
	localparam int TEX_W      = 8;
	localparam int MAT_W      = 3;
	localparam int FACE_W     = 3;
	localparam int NUM_FACES  = 6;
	localparam int NUM_VERTS  = 6;
	localparam int NUM_TEX    = 5;
	localparam int CFG_IDX_W  = 3;

	// Origin bits that take part in the sums.
	localparam logic [POS_W-1:0] POS_MASK =
		(COORD_BITS >= POS_W) ? {POS_W{1'b1}} : POS_W'((1 << COORD_BITS) - 1);

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TEX_GRASS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_DIRT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_STONE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_WATER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_SAND  = 3'd4;

	// Material codes.
	localparam logic [MAT_W-1:0] MAT_GRASS = 3'd0;
	localparam logic [MAT_W-1:0] MAT_DIRT  = 3'd1;
	localparam logic [MAT_W-1:0] MAT_STONE = 3'd2;
	localparam logic [MAT_W-1:0] MAT_WATER = 3'd3;
	localparam logic [MAT_W-1:0] MAT_SAND  = 3'd4;

	// Reset values of the texture registers (Q0.8).
	localparam logic [TEX_W-1:0] TEX_GRASS_RST = 8'd0;
	localparam logic [TEX_W-1:0] TEX_DIRT_RST  = 8'd64;
	localparam logic [TEX_W-1:0] TEX_STONE_RST = 8'd230;
	localparam logic [TEX_W-1:0] TEX_WATER_RST = 8'd192;
	localparam logic [TEX_W-1:0] TEX_SAND_RST  = 8'd128;

	localparam logic [FACE_W-1:0] LAST_VERT = 3'd5;

	// Corner codes: bit 0 adds size_x, bit 1 adds size_y, bit 2 adds size_z.
	localparam logic [2:0] CORNER_TAB [NUM_FACES][NUM_VERTS] = '{
		'{3'd0, 3'd1, 3'd3, 3'd0, 3'd3, 3'd2},  // front
		'{3'd4, 3'd5, 3'd7, 3'd4, 3'd7, 3'd6},  // back
		'{3'd0, 3'd2, 3'd6, 3'd0, 3'd6, 3'd4},  // left
		'{3'd1, 3'd3, 3'd7, 3'd1, 3'd7, 3'd5},  // right
		'{3'd2, 3'd3, 3'd7, 3'd2, 3'd7, 3'd6},  // top
		'{3'd0, 3'd1, 3'd5, 3'd0, 3'd5, 3'd4}   // bottom
	};

	typedef struct packed {
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [POS_W-1:0]  pos_z;
		logic [SIZE_W-1:0] size_x;
		logic [SIZE_W-1:0] size_y;
		logic [SIZE_W-1:0] size_z;
		logic [MAT_W-1:0]  material;
		logic [5:0]        hidden_faces;
	} box_t;

	typedef struct packed {
		logic [VERT_W-1:0] vert_x;
		logic [VERT_W-1:0] vert_y;
		logic [VERT_W-1:0] vert_z;
		logic [TEX_W-1:0]  tex_coord;
		logic [FACE_W-1:0] face_index;
		logic              last_vertex;
	} vertex_t;

	typedef enum logic {ST_IDLE, ST_EMIT} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic advance;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic work;  // the box on the input has at least one vertex
		logic last;  // the vertex shown is the final one of its box
	} status_t;

	typedef struct packed {
		logic              found;
		logic [FACE_W-1:0] idx;
	} face_sel_t;

	// Lowest visible face at or above a start face.
	function automatic face_sel_t next_face(input logic [5:0] mask,
	                                        input logic [FACE_W-1:0] from);
		face_sel_t r;
		r.found = 1'b0;
		r.idx   = '0;
		for (int i = NUM_FACES - 1; i >= 0; i--) begin
			if (FACE_W'(i) >= from && !mask[i]) begin
				r.found = 1'b1;
				r.idx   = FACE_W'(i);
			end
		end
		return r;
	endfunction

endpackage

[hdl/vfve_if.sv]
// Interfaces: the box input channel and the vertex output channel.
interface vfve_box_if;
	logic             valid;
	logic             ready;
	vfve_pkg::box_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface vfve_vert_if;
	logic              valid;
	logic              ready;
	vfve_pkg::vertex_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hdl/vfve_ctrl.sv]
// Controller: state machine that takes boxes and steps through their vertices.
module vfve_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_ready,
	input  vfve_pkg::status_t   status,
	output logic                in_ready,
	output logic                out_valid,
	output vfve_pkg::cmd_t      cmd
);

	vfve_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfve_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd.load    = 1'b0;
		cmd.advance = 1'b0;
		case (state_q)
			vfve_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (status.work) begin
						state_d = vfve_pkg::ST_EMIT;
					end
				end
			end
			vfve_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (status.last) begin
						// The next box may enter as the final vertex leaves.
						in_ready = 1'b1;
						if (in_valid) begin
							cmd.load = 1'b1;
							state_d  = status.work ? vfve_pkg::ST_EMIT : vfve_pkg::ST_IDLE;
						end else begin
							state_d = vfve_pkg::ST_IDLE;
						end
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			default: begin
				state_d = vfve_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/vfve_dp.sv]
// Datapath: texture registers, held box, face and vertex counters and vertex arithmetic.
module vfve_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [vfve_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [vfve_pkg::TEX_W-1:0]          cfg_wdata,
	input  vfve_pkg::box_t                      box_data,
	input  vfve_pkg::cmd_t                      cmd,
	output vfve_pkg::status_t                   status,
	output vfve_pkg::vertex_t                   vert_data
);

	logic [vfve_pkg::TEX_W-1:0]  tex_q [vfve_pkg::NUM_TEX];
	logic [vfve_pkg::POS_W-1:0]  px_q, py_q, pz_q;
	logic [vfve_pkg::SIZE_W-1:0] sx_q, sy_q, sz_q;
	logic [vfve_pkg::TEX_W-1:0]  tc_q;
	logic [5:0]                  mask_q;
	logic [vfve_pkg::FACE_W-1:0] face_q;
	logic [vfve_pkg::FACE_W-1:0] vert_q;

	logic [vfve_pkg::TEX_W-1:0]  tc_in;
	logic                        mat_ok;
	vfve_pkg::face_sel_t         first_sel;
	vfve_pkg::face_sel_t         later_sel;
	logic [2:0]                  corner;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_q[0] <= vfve_pkg::TEX_GRASS_RST;
			tex_q[1] <= vfve_pkg::TEX_DIRT_RST;
			tex_q[2] <= vfve_pkg::TEX_STONE_RST;
			tex_q[3] <= vfve_pkg::TEX_WATER_RST;
			tex_q[4] <= vfve_pkg::TEX_SAND_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				vfve_pkg::REG_TEX_GRASS: tex_q[0] <= cfg_wdata;
				vfve_pkg::REG_TEX_DIRT:  tex_q[1] <= cfg_wdata;
				vfve_pkg::REG_TEX_STONE: tex_q[2] <= cfg_wdata;
				vfve_pkg::REG_TEX_WATER: tex_q[3] <= cfg_wdata;
				vfve_pkg::REG_TEX_SAND:  tex_q[4] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		mat_ok = 1'b1;
		tc_in  = '0;
		case (box_data.material)
			vfve_pkg::MAT_GRASS: tc_in = tex_q[0];
			vfve_pkg::MAT_DIRT:  tc_in = tex_q[1];
			vfve_pkg::MAT_STONE: tc_in = tex_q[2];
			vfve_pkg::MAT_WATER: tc_in = tex_q[3];
			vfve_pkg::MAT_SAND:  tc_in = tex_q[4];
			default:             mat_ok = 1'b0;
		endcase
	end

	assign first_sel   = vfve_pkg::next_face(box_data.hidden_faces, '0);
	assign later_sel   = vfve_pkg::next_face(mask_q, face_q + 3'd1);
	assign status.work = mat_ok && first_sel.found;
	assign status.last = (vert_q == vfve_pkg::LAST_VERT) && !later_sel.found;

	// Box registers hold the last accepted box.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q   <= box_data.pos_x & vfve_pkg::POS_MASK;
			py_q   <= box_data.pos_y & vfve_pkg::POS_MASK;
			pz_q   <= box_data.pos_z & vfve_pkg::POS_MASK;
			sx_q   <= box_data.size_x;
			sy_q   <= box_data.size_y;
			sz_q   <= box_data.size_z;
			tc_q   <= tc_in;
			mask_q <= box_data.hidden_faces;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_q <= '0;
			vert_q <= '0;
		end else if (cmd.load) begin
			face_q <= first_sel.idx;
			vert_q <= '0;
		end else if (cmd.advance) begin
			if (vert_q == vfve_pkg::LAST_VERT) begin
				face_q <= later_sel.idx;
				vert_q <= '0;
			end else begin
				vert_q <= vert_q + 3'd1;
			end
		end
	end

	assign corner = vfve_pkg::CORNER_TAB[face_q][vert_q];

	assign vert_data.vert_x = {1'b0, px_q} +
		(corner[0] ? {{(vfve_pkg::VERT_W - vfve_pkg::SIZE_W){1'b0}}, sx_q} : '0);
	assign vert_data.vert_y = {1'b0, py_q} +
		(corner[1] ? {{(vfve_pkg::VERT_W - vfve_pkg::SIZE_W){1'b0}}, sy_q} : '0);
	assign vert_data.vert_z = {1'b0, pz_q} +
		(corner[2] ? {{(vfve_pkg::VERT_W - vfve_pkg::SIZE_W){1'b0}}, sz_q} : '0);
	assign vert_data.tex_coord   = tc_q;
	assign vert_data.face_index  = face_q;
	assign vert_data.last_vertex = status.last;

endmodule

[hdl/voxel_face_vertex_emitter.sv]
// Top level of the voxel face vertex emitter: controller, datapath and checks.
//
//  channel   direction  handshake      payload
//  box       in         valid/ready    pos_x/y/z, size_x/y/z, material, hidden_faces
//  vertex    out        valid/ready    vert_x/y/z, tex_coord, face_index, last_vertex
//  cfg       in         cfg_we         cfg_idx, cfg_wdata (write only)
//
// A box with n visible faces gives 6*n vertices, so at most 36, one vertex per cycle
// while the vertex channel is ready. The face and vertex counters in the datapath set
// that figure; a box that emits nothing (unknown material or all faces hidden) is still taken.
// The next box is taken in the cycle that the final vertex of the current box leaves.
// arst_n clears the state machine and counters and loads the texture defaults.
// A stall on the vertex channel holds the vertex shown and stops the counters.
module voxel_face_vertex_emitter (
	input  logic                            clk,
	input  logic                            arst_n,
	vfve_box_if.sink                        box,
	vfve_vert_if.source                     vertex,
	input  logic                            cfg_we,
	input  logic [vfve_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [vfve_pkg::TEX_W-1:0]      cfg_wdata
);

	vfve_pkg::cmd_t    cmd;
	vfve_pkg::status_t status;
	logic              in_ready;
	logic              out_valid;

	// The controller only sequences; all values live in the datapath.
	vfve_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (box.valid),
		.out_ready (vertex.ready),
		.status    (status),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	vfve_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.box_data  (box.data),
		.cmd       (cmd),
		.status    (status),
		.vert_data (vertex.data)
	);

	assign box.ready    = in_ready;
	assign vertex.valid = out_valid;

	// A new box enters only when no vertex is pending, or the final one is leaving.
	a_take_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		box.valid && box.ready |-> !vertex.valid || (vertex.ready && vertex.data.last_vertex))
		else $error("box taken while vertices of the previous box were pending");

	// Taking a vertex that is not the final one leaves another vertex to show.
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid && vertex.ready && !vertex.data.last_vertex |=> vertex.valid)
		else $error("vertex stream of a box ended without a final vertex");

	// A vertex always names a real face.
	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid |-> vertex.data.face_index < vfve_pkg::FACE_W'(vfve_pkg::NUM_FACES))
		else $error("vertex carries a face index out of range");

	// Loading and stepping never happen together.
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.advance))
		else $error("load and advance issued in the same cycle");

endmodule

[tb/vfve_checker.sv]
// Checker: predicts the vertices of every accepted box and compares them with the block's output.
module vfve_checker
	import vfve_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	vfve_box_if                  box,
	vfve_vert_if                 vertex,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [TEX_W-1:0]     cfg_wdata,
	output int                   errors,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 40;

	localparam logic [POS_W-1:0] ORIGIN_MASK =
		(COORD_BITS >= POS_W) ? {POS_W{1'b1}} : POS_W'((1 << COORD_BITS) - 1);

	// Corner of each vertex: bit 0 takes size_x, bit 1 size_y, bit 2 size_z.
	localparam logic [2:0] FACE_CORNERS [NUM_FACES][NUM_VERTS] = '{
		'{3'b000, 3'b001, 3'b011, 3'b000, 3'b011, 3'b010},
		'{3'b100, 3'b101, 3'b111, 3'b100, 3'b111, 3'b110},
		'{3'b000, 3'b010, 3'b110, 3'b000, 3'b110, 3'b100},
		'{3'b001, 3'b011, 3'b111, 3'b001, 3'b111, 3'b101},
		'{3'b010, 3'b011, 3'b111, 3'b010, 3'b111, 3'b110},
		'{3'b000, 3'b001, 3'b101, 3'b000, 3'b101, 3'b100}
	};

	localparam logic [TEX_W-1:0] TEX_DEFAULTS [NUM_TEX] =
		'{8'd0, 8'd64, 8'd230, 8'd192, 8'd128};

	logic [TEX_W-1:0] tex_table [NUM_TEX];
	vertex_t          pending_vertices [$];

	task automatic report_mismatch(input string msg);
		if (errors < MAX_REPORTS)
			$display("%0t ns vertex mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
	                             input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	// Appends the vertices that one box gives, in emission order.
	function automatic void emit_box_vertices(input box_t b);
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		logic [POS_W-1:0] pz;
		logic [2:0]       c;
		vertex_t          v;
		int               start_count;
		start_count = pending_vertices.size();
		px = b.pos_x & ORIGIN_MASK;
		py = b.pos_y & ORIGIN_MASK;
		pz = b.pos_z & ORIGIN_MASK;
		if (b.material >= NUM_TEX)
			return;
		for (int f = 0; f < NUM_FACES; f++) begin
			if (!b.hidden_faces[f]) begin
				for (int k = 0; k < NUM_VERTS; k++) begin
					c = FACE_CORNERS[f][k];
					v.vert_x      = VERT_W'(px) + (c[0] ? VERT_W'(b.size_x) : VERT_W'(0));
					v.vert_y      = VERT_W'(py) + (c[1] ? VERT_W'(b.size_y) : VERT_W'(0));
					v.vert_z      = VERT_W'(pz) + (c[2] ? VERT_W'(b.size_z) : VERT_W'(0));
					v.tex_coord   = tex_table[b.material];
					v.face_index  = FACE_W'(f);
					v.last_vertex = 1'b0;
					pending_vertices.push_back(v);
				end
			end
		end
		if (pending_vertices.size() > start_count)
			pending_vertices[pending_vertices.size() - 1].last_vertex = 1'b1;
	endfunction

	task automatic check_vertex(input vertex_t got);
		vertex_t want;
		if (pending_vertices.size() == 0) begin
			report_mismatch($sformatf("vertex %p with none expected", got));
			return;
		end
		want = pending_vertices.pop_front();
		compare_field("vert_x", got.vert_x, want.vert_x);
		compare_field("vert_y", got.vert_y, want.vert_y);
		compare_field("vert_z", got.vert_z, want.vert_z);
		compare_field("tex_coord", got.tex_coord, want.tex_coord);
		compare_field("face_index", got.face_index, want.face_index);
		compare_field("last_vertex", got.last_vertex, want.last_vertex);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (tex_table[i])
				tex_table[i] = TEX_DEFAULTS[i];
			pending_vertices.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we && cfg_idx < NUM_TEX)
				tex_table[cfg_idx] = cfg_wdata;
			// New box first: its vertices go behind any still queued.
			if (box.valid && box.ready)
				emit_box_vertices(box.data);
			if (vertex.valid && vertex.ready)
				check_vertex(vertex.data);
			outstanding <= pending_vertices.size();
		end
	end

endmodule

[tb/voxel_face_vertex_emitter_test.sv]
// Testbench top: drives boxes and texture registers into the emitter and gives the verdict.
module voxel_face_vertex_emitter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import vfve_pkg::*;

	localparam int RESET_CYCLES  = 10;
	// Settling time after the vertex queue empties, to cover a box that emits nothing.
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 20;
	localparam int IDLE_PCT      = 16;
	localparam int BATCH_ITEMS   = 115;
	// The slowest correct run is about 480 boxes of 36 vertices with stalls on
	// both sides; the limit leaves a wide margin on top.
	localparam int CYCLE_LIMIT   = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [TEX_W-1:0]     cfg_wdata;
	int                   error_count;
	int                   outstanding;
	int                   idle_pct;
	int                   cycle_count = 0;

	vfve_box_if  box_ch ();
	vfve_vert_if vert_ch ();

	voxel_face_vertex_emitter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.box       (box_ch),
		.vertex    (vert_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// The checker follows both channels and the register writes on its own.
	vfve_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.box         (box_ch),
		.vertex      (vert_ch),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.errors      (error_count),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// The whole run is bounded; a hang anywhere ends here.
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// The vertex side drops ready at random, with the same idle rate as the
	// sender, so stalls land on every vertex position within a box.
	initial begin : vertex_sink
		vert_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			vert_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	function automatic box_t make_box(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
	                                  input logic [POS_W-1:0] pz, input logic [SIZE_W-1:0] sx,
	                                  input logic [SIZE_W-1:0] sy, input logic [SIZE_W-1:0] sz,
	                                  input logic [MAT_W-1:0] mat, input logic [5:0] hid);
		box_t b;
		b.pos_x        = px;
		b.pos_y        = py;
		b.pos_z        = pz;
		b.size_x       = sx;
		b.size_y       = sy;
		b.size_z       = sz;
		b.material     = mat;
		b.hidden_faces = hid;
		return b;
	endfunction

	// Origins lean toward the ends of the range so that carries into bit 16 are common.
	function automatic logic [POS_W-1:0] random_pos();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return POS_W'($urandom_range(0, 255)) | {8'hFF, 8'h00};
			default: return POS_W'($urandom);
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] random_size();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return SIZE_W'($urandom);
		endcase
	endfunction

	// Mostly known materials with a random mask; now and then an unknown
	// material or a box with every face hidden, which emit nothing.
	function automatic box_t random_box();
		logic [MAT_W-1:0] mat;
		logic [5:0]       hid;
		if ($urandom_range(0, 99) < 88)
			mat = MAT_W'($urandom_range(0, NUM_TEX - 1));
		else
			mat = MAT_W'($urandom_range(NUM_TEX, (1 << MAT_W) - 1));
		case ($urandom_range(0, 9))
			0:       hid = '0;
			1:       hid = '1;
			default: hid = 6'($urandom);
		endcase
		return make_box(random_pos(), random_pos(), random_pos(),
		                random_size(), random_size(), random_size(), mat, hid);
	endfunction

	// Presents one box and returns once it has been accepted. Idle cycles
	// ahead of the box keep valid low; back-to-back boxes keep it high.
	task automatic send_box(input box_t b);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			box_ch.valid <= 1'b0;
			@(negedge clk);
		end
		box_ch.valid <= 1'b1;
		box_ch.data  <= b;
		@(posedge clk);
		while (!box_ch.ready) @(posedge clk);
	endtask

	task automatic send_random_boxes(input int count);
		repeat (count) send_box(random_box());
	endtask

	// Holds the sender back until every expected vertex has come out, then waits
	// SETTLE_CYCLES more in case the last box was one that emits nothing.
	task automatic wait_idle();
		@(negedge clk);
		box_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_tex(input logic [CFG_IDX_W-1:0] idx, input logic [TEX_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_tex_table(input logic [TEX_W-1:0] grass, input logic [TEX_W-1:0] dirt,
	                             input logic [TEX_W-1:0] stone, input logic [TEX_W-1:0] water,
	                             input logic [TEX_W-1:0] sand);
		write_tex(REG_TEX_GRASS, grass);
		write_tex(REG_TEX_DIRT, dirt);
		write_tex(REG_TEX_STONE, stone);
		write_tex(REG_TEX_WATER, water);
		write_tex(REG_TEX_SAND, sand);
	endtask

	// Writes to indexes past the last register must leave the table alone.
	task automatic poke_unused_regs();
		for (int i = NUM_TEX; i < (1 << CFG_IDX_W); i++)
			write_tex(CFG_IDX_W'(i), TEX_W'($urandom));
	endtask

	initial begin : stimulus
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = '0;
		cfg_wdata    = '0;
		box_ch.valid = 1'b0;
		box_ch.data  = '0;
		idle_pct     = IDLE_PCT;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, run with the texture defaults from reset. First the
		// all-zero box and the box at the top of every field, which carries
		// into the seventeenth bit on all three axes.
		send_box(make_box('0, '0, '0, '0, '0, '0, MAT_GRASS, '0));
		send_box(make_box('1, '1, '1, '1, '1, '1, MAT_SAND, '0));
		// Every known material once.
		for (int m = 0; m < NUM_TEX; m++)
			send_box(make_box(random_pos(), random_pos(), random_pos(), random_size(),
			                  random_size(), random_size(), MAT_W'(m), 6'($urandom)));
		// Unknown materials give no vertices, and neither does a fully hidden box.
		for (int m = NUM_TEX; m < (1 << MAT_W); m++)
			send_box(make_box(random_pos(), random_pos(), random_pos(), random_size(),
			                  random_size(), random_size(), MAT_W'(m), '0));
		send_box(make_box(random_pos(), random_pos(), random_pos(), random_size(),
		                  random_size(), random_size(), MAT_STONE, '1));
		// One visible face at a time, so each face's corner order stands alone
		// and each is the final face of its box.
		for (int f = 0; f < NUM_FACES; f++)
			send_box(make_box(random_pos(), random_pos(), random_pos(), random_size(),
			                  random_size(), random_size(), MAT_WATER, ~(6'b1 << f)));

		// Top of the texture range, with writes to the unused indexes.
		wait_idle();
		set_tex_table('1, '1, '1, '1, '1);
		poke_unused_regs();
		send_random_boxes(BATCH_ITEMS);

		// Bottom of the range, and a long stretch with no idling on either side.
		wait_idle();
		set_tex_table('0, '0, '0, '0, '0);
		idle_pct = 0;
		send_random_boxes(BATCH_ITEMS);
		idle_pct = IDLE_PCT;

		// Random values everywhere.
		wait_idle();
		set_tex_table(TEX_W'($urandom), TEX_W'($urandom), TEX_W'($urandom),
		              TEX_W'($urandom), TEX_W'($urandom));
		poke_unused_regs();
		send_random_boxes(BATCH_ITEMS);

		// Alternating patterns, so that grass and dirt, and stone and water, differ in every bit.
		wait_idle();
		set_tex_table(8'h55, 8'hAA, 8'h0F, 8'hF0, TEX_W'($urandom));
		send_random_boxes(BATCH_ITEMS);

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
